[design/vertex_clip_divide_viewport_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vertex clip, divide and viewport block.
// Both macros expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef VERTEX_CLIP_DIVIDE_VIEWPORT_ASSERT_SVH
`define VERTEX_CLIP_DIVIDE_VIEWPORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCDV_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcdv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VCDV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcdv assertion failed");

`endif

[design/vcdv_pkg.sv]
// ----------------------------------------------------------------------------
// vcdv_pkg
// Shared constants and types for the vertex transform and divide pipeline.
// ----------------------------------------------------------------------------
package vcdv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int NUM_ROWS      = 4;
    localparam int NUM_LANES     = 3;
    localparam int Q_BITS        = 32;
    localparam int W_BITS        = 64;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CLIP = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    // Per-word side information that rides along the divider chain.
    typedef struct packed {
        logic                 clip;
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] ovf;
    } vcdv_flags_t;

endpackage

[design/vertex_clip_divide_viewport.sv]
// ----------------------------------------------------------------------------
// vertex_clip_divide_viewport
// Transforms a world point by a 4x4 fixed-point matrix and divides by clip w.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; the 32-cell
// division chain is fully pipelined. A word passes the multiply, sum and prepare
// stages, the 32 divider cells, one quotient bit per cell, and the output stage.
// Reset (rst_n low, asynchronous) clears all valid flags and the matrix registers.
module vertex_clip_divide_viewport #(
    parameter int FRAC_BITS = vcdv_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port, eight 64-bit registers at byte address 8*i.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input word channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] world_x,
    input  logic signed [31:0] world_y,
    input  logic signed [31:0] world_z,
    // Result word channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] depth,
    output logic [1:0]  status
);
    import vcdv_pkg::*;

    localparam int NUM_CELLS = Q_BITS;
    localparam int SUM_BITS  = 66;
    localparam int DSH_BITS  = W_BITS + Q_BITS;

    // ------------------------------------------------------------------
    // Matrix registers. Each register holds two signed coefficients, the
    // first in the low half and the second in the high half.
    // ------------------------------------------------------------------
    logic [63:0] mat_reg [NUM_REGS];
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = mat_reg[paddr[5:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            mat_reg[paddr[5:3]] <= pwdata;
        end
    end

    logic signed [31:0] coef [NUM_ROWS][NUM_ROWS];
    logic signed [31:0] point [NUM_LANES];

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                coef[r][2*h]   = mat_reg[2*r+h][31:0];
                coef[r][2*h+1] = mat_reg[2*r+h][63:32];
            end
        end
        point[0] = world_x;
        point[1] = world_y;
        point[2] = world_z;
    end

    // ------------------------------------------------------------------
    // Handshake. Every stage moves when it is empty or its successor moves,
    // so bubbles close up and a waiting result blocks intake only once all stages are full.
    // ------------------------------------------------------------------
    logic                 va_reg, vb_reg, vc_reg, out_valid_reg;
    logic                 en_a, en_b, en_c, out_en;
    logic [NUM_CELLS:0]   chain_valid;
    logic [NUM_CELLS:0]   chain_ready;

    assign out_en   = !out_valid_reg || out_ready;
    assign en_c     = !vc_reg || chain_ready[0];
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= in_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= chain_valid[NUM_CELLS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: the twelve coefficient-by-coordinate products. The
    // translation coefficients are carried along for stage B.
    // ------------------------------------------------------------------
    logic signed [63:0] prod_reg [NUM_ROWS][NUM_LANES];
    logic signed [31:0] tr_reg [NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (in_valid && en_a)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < NUM_LANES; c++)
                begin
                    prod_reg[r][c] <= coef[r][c] * point[c];
                end
                tr_reg[r] <= coef[r][NUM_ROWS-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: exact row sums, scale 2^(2*FRAC_BITS), 66 bits signed.
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0] sum_reg [NUM_ROWS];
    logic signed [SUM_BITS-1:0] sum_next [NUM_ROWS];

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            sum_next[r] = SUM_BITS'(prod_reg[r][0]) + SUM_BITS'(prod_reg[r][1])
                        + SUM_BITS'(prod_reg[r][2])
                        + (SUM_BITS'(tr_reg[r]) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (va_reg && en_b)
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: clip test, magnitudes and the dividend split. The dividend
    // is |c| * 2^FRAC_BITS; its upper part seeds the remainder and its low
    // 32 bits are shifted in by the cells. A quotient of 2^32 or more is
    // flagged here as an overflow.
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]                w_next, w_c_reg;
    vcdv_flags_t                      flags_next, flags_c_reg;
    logic [NUM_LANES-1:0][W_BITS-1:0] hi_next, hi_c_reg;
    logic [NUM_LANES-1:0][Q_BITS-1:0] lo_next, lo_c_reg;
    logic [SUM_BITS-1:0]              mag66 [NUM_LANES];
    logic [DSH_BITS-1:0]              dsh [NUM_LANES];

    always_comb
    begin
        w_next          = sum_reg[NUM_ROWS-1][W_BITS-1:0];
        flags_next.clip = sum_reg[NUM_ROWS-1][SUM_BITS-1] || (sum_reg[NUM_ROWS-1] == '0);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            flags_next.neg[l] = sum_reg[l][SUM_BITS-1];
            mag66[l]          = flags_next.neg[l] ? SUM_BITS'(-sum_reg[l])
                                                  : SUM_BITS'(sum_reg[l]);
            dsh[l]            = {{Q_BITS{1'b0}}, mag66[l][W_BITS-1:0]} << FRAC_BITS;
            hi_next[l]        = dsh[l][DSH_BITS-1:Q_BITS];
            lo_next[l]        = dsh[l][Q_BITS-1:0];
            flags_next.ovf[l] = hi_next[l] >= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vb_reg && en_c)
        begin
            w_c_reg     <= w_next;
            flags_c_reg <= flags_next;
            hi_c_reg    <= hi_next;
            lo_c_reg    <= lo_next;
        end
    end

    // ------------------------------------------------------------------
    // Division chain: one quotient bit per cell, most significant first.
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]                chain_w     [NUM_CELLS+1];
    logic [NUM_LANES-1:0][W_BITS-1:0] chain_rem   [NUM_CELLS+1];
    logic [NUM_LANES-1:0][Q_BITS-1:0] chain_low   [NUM_CELLS+1];
    logic [NUM_LANES-1:0][Q_BITS-1:0] chain_quo   [NUM_CELLS+1];
    vcdv_flags_t                      chain_flags [NUM_CELLS+1];

    assign chain_valid[0]         = vc_reg;
    assign chain_w[0]             = w_c_reg;
    assign chain_rem[0]           = hi_c_reg;
    assign chain_low[0]           = lo_c_reg;
    assign chain_quo[0]           = '0;
    assign chain_flags[0]         = flags_c_reg;
    assign chain_ready[NUM_CELLS] = out_en;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        vcdv_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (chain_valid[k]),
            .up_ready  (chain_ready[k]),
            .w_in      (chain_w[k]),
            .rem_in    (chain_rem[k]),
            .low_in    (chain_low[k]),
            .quo_in    (chain_quo[k]),
            .flags_in  (chain_flags[k]),
            .dn_valid  (chain_valid[k+1]),
            .dn_ready  (chain_ready[k+1]),
            .w_out     (chain_w[k+1]),
            .rem_out   (chain_rem[k+1]),
            .low_out   (chain_low[k+1]),
            .quo_out   (chain_quo[k+1]),
            .flags_out (chain_flags[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: saturate to the signed 32-bit range, restore the sign,
    // zero the results of a clipped vertex, and report clip or saturation in status.
    // ------------------------------------------------------------------
    vcdv_flags_t                      fin_flags;
    logic [NUM_LANES-1:0][Q_BITS-1:0] fin_quo;
    logic [Q_BITS-1:0]                lim [NUM_LANES];
    logic [Q_BITS-1:0]                mag_q [NUM_LANES];
    logic [NUM_LANES-1:0]             sat;
    logic [Q_BITS-1:0]                res_next [NUM_LANES];
    status_t                          status_next;
    logic [Q_BITS-1:0]                res_reg [NUM_LANES];
    status_t                          status_reg;

    assign fin_flags = chain_flags[NUM_CELLS];
    assign fin_quo   = chain_quo[NUM_CELLS];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lim[l]   = fin_flags.neg[l] ? {1'b1, {(Q_BITS-1){1'b0}}}
                                        : {1'b0, {(Q_BITS-1){1'b1}}};
            sat[l]   = fin_flags.ovf[l] || (fin_quo[l] > lim[l]);
            mag_q[l] = sat[l] ? lim[l] : fin_quo[l];
            if (fin_flags.clip)
            begin
                res_next[l] = '0;
            end
            else
            begin
                res_next[l] = fin_flags.neg[l] ? Q_BITS'(-mag_q[l]) : mag_q[l];
            end
        end
        priority if (fin_flags.clip)
        begin
            status_next = STATUS_CLIP;
        end
        else if (sat != '0)
        begin
            status_next = STATUS_SAT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[NUM_CELLS] && out_en)
        begin
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = res_reg[0];
    assign screen_y  = res_reg[1];
    assign depth     = res_reg[2];
    assign status    = status_reg;

endmodule

[design/vcdv_div_cell.sv]
// ----------------------------------------------------------------------------
// vcdv_div_cell
// One restoring-division step for three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module vcdv_div_cell (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             up_valid,
    output logic                                             up_ready,
    input  logic [vcdv_pkg::W_BITS-1:0]                      w_in,
    input  logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::W_BITS-1:0] rem_in,
    input  logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::Q_BITS-1:0] low_in,
    input  logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::Q_BITS-1:0] quo_in,
    input  vcdv_pkg::vcdv_flags_t                            flags_in,
    output logic                                             dn_valid,
    input  logic                                             dn_ready,
    output logic [vcdv_pkg::W_BITS-1:0]                      w_out,
    output logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::W_BITS-1:0] rem_out,
    output logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::Q_BITS-1:0] low_out,
    output logic [vcdv_pkg::NUM_LANES-1:0][vcdv_pkg::Q_BITS-1:0] quo_out,
    output vcdv_pkg::vcdv_flags_t                            flags_out
);
    import vcdv_pkg::*;

    logic                                  valid_reg;
    logic [W_BITS-1:0]                     w_reg;
    logic [NUM_LANES-1:0][W_BITS-1:0]      rem_reg;
    logic [NUM_LANES-1:0][W_BITS-1:0]      rem_next;
    logic [NUM_LANES-1:0][Q_BITS-1:0]      low_reg;
    logic [NUM_LANES-1:0][Q_BITS-1:0]      low_next;
    logic [NUM_LANES-1:0][Q_BITS-1:0]      quo_reg;
    logic [NUM_LANES-1:0][Q_BITS-1:0]      quo_next;
    vcdv_flags_t                           flags_reg;
    logic [W_BITS:0]                       trial [NUM_LANES];
    logic [W_BITS:0]                       diff [NUM_LANES];
    logic                                  load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            trial[l] = {rem_in[l], low_in[l][Q_BITS-1]};
            diff[l]  = trial[l] - {1'b0, w_in};
            if (trial[l] >= {1'b0, w_in})
            begin
                rem_next[l] = diff[l][W_BITS-1:0];
                quo_next[l] = {quo_in[l][Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial[l][W_BITS-1:0];
                quo_next[l] = {quo_in[l][Q_BITS-2:0], 1'b0};
            end
            low_next[l] = {low_in[l][Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg     <= w_in;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            quo_reg   <= quo_next;
            flags_reg <= flags_in;
        end
    end

    assign dn_valid  = valid_reg;
    assign w_out     = w_reg;
    assign rem_out   = rem_reg;
    assign low_out   = low_reg;
    assign quo_out   = quo_reg;
    assign flags_out = flags_reg;

endmodule

[design/vcdv_checker.sv]
// ----------------------------------------------------------------------------
// vcdv_checker
// Port-level assertions for the vertex clip, divide and viewport block.
// ----------------------------------------------------------------------------
`include "vertex_clip_divide_viewport_assert.svh"

module vcdv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] screen_x,
    input logic [31:0] screen_y,
    input logic [31:0] depth,
    input logic [1:0]  status
);
    import vcdv_pkg::*;

    // The configuration port never inserts wait states.
    `VCDV_ASSERT_NOW(a_pready_high, 1'b1, pready)

    // A clipped vertex carries all-zero coordinates.
    `VCDV_ASSERT_NOW(a_clip_zero, out_valid && (status == STATUS_CLIP),
        (screen_x == '0) && (screen_y == '0) && (depth == '0))

    // Status only ever takes one of its three defined codes.
    `VCDV_ASSERT_NOW(a_status_code, out_valid,
        (status == STATUS_OK) || (status == STATUS_CLIP) || (status == STATUS_SAT))

    // A stalled result word holds until it is taken.
    `VCDV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(screen_x) && $stable(screen_y) && $stable(depth)
        && $stable(status))

endmodule

bind vertex_clip_divide_viewport vcdv_checker u_vcdv_checker (.*);
